// File: rtl/core/xcfr_pkg.sv
package xcfr_pkg;

  localparam int MAX_PAYLOAD_DEF = 64;
  localparam int QUEUE_DEPTH     = 2;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [7:0]  START_RESET  = 8'hAA;
  localparam logic [15:0] HDR_TO_RESET = 16'd800;
  localparam logic [15:0] BODY_TO_RESET = 16'd200;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_TO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BODY_TO = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_START = 3'd1;
  localparam logic [2:0] ST_TOO_LONG  = 3'd2;
  localparam logic [2:0] ST_BAD_SUM   = 3'd3;
  localparam logic [2:0] ST_TIMEOUT   = 3'd4;

  // input command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // one finished frame, handed from the parser to the drain side
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] code;
    logic [7:0] length;
  } job_t;

  // payload store write port
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } mem_wr_t;

endpackage

// File: rtl/core/xcfr_queue.sv
module xcfr_queue import xcfr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slot_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = slot_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

endmodule

// File: rtl/core/xcfr_front.sv
module xcfr_front import xcfr_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_command,
  input  logic [7:0]           in_rx_byte,
  input  logic                 q_full,
  output logic                 q_push,
  output job_t                 q_job,
  input  logic                 drain_done,
  output mem_wr_t              mem_wr
);

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_CHECK  = 2'd2;

  logic [7:0]  start_r;
  logic [15:0] hdr_to_r;
  logic [15:0] body_to_r;

  logic [1:0]       phase_r, phase_nxt;
  logic [1:0]       hcnt_r, hcnt_nxt;
  logic [7:0]       first_r, first_nxt;
  logic [7:0]       code_r, code_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] bcnt_r, bcnt_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [15:0]      tick_r, tick_nxt;
  logic             busy_r, busy_nxt;

  logic             in_acc;
  logic [16:0]      tick_inc;
  logic [15:0]      limit;
  logic [LEN_W-1:0] bcnt_inc;
  logic             restart;

  // payload store is shared: hold off new payload until the drain has read it out
  assign in_stall = q_full || ((phase_r == PH_BODY) && busy_r);
  assign in_acc   = in_valid && !in_stall;
  assign tick_inc = {1'b0, tick_r} + 17'd1;
  assign limit    = (phase_r == PH_HEADER) ? hdr_to_r : body_to_r;
  assign bcnt_inc = bcnt_r + LEN_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= START_RESET;
      hdr_to_r  <= HDR_TO_RESET;
      body_to_r <= BODY_TO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START:   start_r   <= cfg_wdata[7:0];
        CFG_HDR_TO:  hdr_to_r  <= cfg_wdata;
        CFG_BODY_TO: body_to_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    first_nxt = first_r;
    code_nxt  = code_r;
    len_nxt   = len_r;
    bcnt_nxt  = bcnt_r;
    xor_nxt   = xor_r;
    tick_nxt  = tick_r;
    busy_nxt  = busy_r;
    restart   = 1'b0;
    q_push    = 1'b0;
    q_job     = '{status: ST_OK, code: code_r, length: 8'(len_r)};
    mem_wr    = '{en: 1'b0, addr: 8'(bcnt_r), data: in_rx_byte};

    if (drain_done) begin
      busy_nxt = 1'b0;
    end

    if (in_acc) begin
      if (in_command == CMD_TICK) begin
        if (tick_inc < {1'b0, limit}) begin
          tick_nxt = tick_inc[15:0];
        end else if (phase_r == PH_HEADER && hcnt_r == 2'd0) begin
          restart = 1'b1;
        end else begin
          q_push       = 1'b1;
          q_job.status = ST_TIMEOUT;
          restart      = 1'b1;
        end
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            if (hcnt_r == 2'd0) begin
              first_nxt = in_rx_byte;
              hcnt_nxt  = 2'd1;
            end else if (hcnt_r == 2'd1) begin
              code_nxt = in_rx_byte;
              hcnt_nxt = 2'd2;
            end else begin
              hcnt_nxt = 2'd3;
              if (first_r != start_r) begin
                q_push       = 1'b1;
                q_job.status = ST_BAD_START;
                q_job.length = in_rx_byte;
                restart      = 1'b1;
              end else if (in_rx_byte > 8'(MAX_PAYLOAD)) begin
                q_push       = 1'b1;
                q_job.status = ST_TOO_LONG;
                q_job.length = in_rx_byte;
                restart      = 1'b1;
              end else begin
                len_nxt   = in_rx_byte[LEN_W-1:0];
                xor_nxt   = code_r ^ in_rx_byte;
                bcnt_nxt  = '0;
                tick_nxt  = '0;
                phase_nxt = (in_rx_byte == 8'd0) ? PH_CHECK : PH_BODY;
              end
            end
          end
          PH_BODY: begin
            mem_wr.en = 1'b1;
            xor_nxt   = xor_r ^ in_rx_byte;
            bcnt_nxt  = bcnt_inc;
            if (bcnt_inc >= len_r) begin
              phase_nxt = PH_CHECK;
              tick_nxt  = '0;
            end
          end
          PH_CHECK: begin
            q_push  = 1'b1;
            restart = 1'b1;
            if (in_rx_byte != xor_r) begin
              q_job.status = ST_BAD_SUM;
            end else if (len_r != '0) begin
              busy_nxt = 1'b1;
            end
          end
          default: begin
            restart = 1'b1;
          end
        endcase
      end
    end

    if (restart) begin
      phase_nxt = PH_HEADER;
      hcnt_nxt  = '0;
      first_nxt = '0;
      code_nxt  = '0;
      len_nxt   = '0;
      bcnt_nxt  = '0;
      xor_nxt   = '0;
      tick_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hcnt_r  <= '0;
      first_r <= '0;
      code_r  <= '0;
      len_r   <= '0;
      bcnt_r  <= '0;
      xor_r   <= '0;
      tick_r  <= '0;
      busy_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      first_r <= first_nxt;
      code_r  <= code_nxt;
      len_r   <= len_nxt;
      bcnt_r  <= bcnt_nxt;
      xor_r   <= xor_nxt;
      tick_r  <= tick_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

// File: rtl/core/xcfr_back.sv
module xcfr_back import xcfr_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  mem_wr_t    mem_wr,
  input  logic       q_empty,
  input  job_t       q_job,
  output logic       q_pop,
  output logic       drain_done,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [7:0] out_frame_code,
  output logic [6:0] out_frame_length,
  output logic       out_has_payload,
  output logic [7:0] out_payload_byte,
  output logic       out_last
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic [7:0] mem [MAX_PAYLOAD];
  logic [7:0] rdata_r;

  logic       state_r, state_nxt;
  logic [7:0] idx_r, idx_nxt;
  logic [7:0] code_r, code_nxt;
  logic [7:0] len_r, len_nxt;

  logic       ovalid_r, ovalid_nxt;
  logic [2:0] ostatus_r, ostatus_nxt;
  logic [7:0] ocode_r, ocode_nxt;
  logic [6:0] olen_r, olen_nxt;
  logic       ohas_r, ohas_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic       olast_r, olast_nxt;

  logic       out_free;
  logic       job_payload;
  logic       beat_last;
  logic       rd_en;
  logic [7:0] rd_addr;
  logic [7:0] idx_inc;

  function automatic logic [6:0] sat_len(input logic [7:0] len);
    return (len > 8'd127) ? 7'd127 : len[6:0];
  endfunction

  assign out_free    = !ovalid_r || !out_stall;
  assign job_payload = (q_job.status == ST_OK) && (q_job.length != 8'd0);
  assign idx_inc     = idx_r + 8'd1;
  assign beat_last   = (idx_inc == len_r);

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    code_nxt    = code_r;
    len_nxt     = len_r;
    ovalid_nxt  = ovalid_r && out_stall;
    ostatus_nxt = ostatus_r;
    ocode_nxt   = ocode_r;
    olen_nxt    = olen_r;
    ohas_nxt    = ohas_r;
    obyte_nxt   = obyte_r;
    olast_nxt   = olast_r;
    q_pop       = 1'b0;
    drain_done  = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = idx_inc;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          if (job_payload) begin
            code_nxt  = q_job.code;
            len_nxt   = q_job.length;
            idx_nxt   = '0;
            rd_en     = 1'b1;
            rd_addr   = '0;
            state_nxt = S_READ;
          end else begin
            ovalid_nxt  = 1'b1;
            ostatus_nxt = q_job.status;
            ocode_nxt   = q_job.code;
            olen_nxt    = sat_len(q_job.length);
            ohas_nxt    = 1'b0;
            obyte_nxt   = '0;
            olast_nxt   = 1'b1;
          end
        end
      end
      S_READ: begin
        // read data for idx_r is valid and held until the beat is loaded
        if (out_free) begin
          ovalid_nxt  = 1'b1;
          ostatus_nxt = ST_OK;
          ocode_nxt   = code_r;
          olen_nxt    = sat_len(len_r);
          ohas_nxt    = 1'b1;
          obyte_nxt   = rdata_r;
          olast_nxt   = beat_last;
          if (beat_last) begin
            drain_done = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            idx_nxt = idx_inc;
            rd_en   = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.addr[AW-1:0]] <= mem_wr.data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    code_r    <= code_nxt;
    len_r     <= len_nxt;
    ostatus_r <= ostatus_nxt;
    ocode_r   <= ocode_nxt;
    olen_r    <= olen_nxt;
    ohas_r    <= ohas_nxt;
    obyte_r   <= obyte_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_valid        = ovalid_r;
  assign out_status       = ostatus_r;
  assign out_frame_code   = ocode_r;
  assign out_frame_length = olen_r;
  assign out_has_payload  = ohas_r;
  assign out_payload_byte = obyte_r;
  assign out_last         = olast_r;

endmodule

// File: rtl/core/xor_checked_frame_receiver_core.sv
// Frame receiver: start byte, code, length, payload, XOR checksum.
// Input beats carry either a received serial byte (command 0) or a one
// millisecond tick (command 1). Each beat is taken while in_stall is low; a parser
// classifies it and writes payload bytes into a local store.
// A finished frame goes through a two-entry queue to the drain side, which
// emits one result beat per payload byte (last marked), one beat for an
// empty good frame, or one status beat for a rejected or timed-out frame.
// A status beat passes the queue and output register; the first payload beat
// also the store read register, then one beat per cycle while not stalled.
// The payload store has one write and one read port, so once a frame with
// payload is queued, the next frame's payload phase (bytes and ticks) is
// held off (in_stall) until that payload has been read out; header,
// checksum and header-window tick beats keep flowing unless the queue is full.
// When the receiver asserts out_stall the current beat holds; the queue
// then fills and in_stall rises.
// Configuration (start byte, header timeout, body timeout) is written via
// cfg_we/cfg_index/cfg_wdata; the user must do so only while idle, which
// the block does not enforce. Synchronous reset restores register defaults
// and empties parser, queue and output; the payload store is not cleared.
module xor_checked_frame_receiver_core import xcfr_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_command,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_status,
  output logic [7:0]           out_frame_code,
  output logic [6:0]           out_frame_length,
  output logic                 out_has_payload,
  output logic [7:0]           out_payload_byte,
  output logic                 out_last
);

  logic    q_push, q_pop, q_full, q_empty, drain_done;
  job_t    push_job, pop_job;
  mem_wr_t mem_wr;

  xcfr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job),
    .drain_done (drain_done),
    .mem_wr     (mem_wr)
  );

  xcfr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  xcfr_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .mem_wr           (mem_wr),
    .q_empty          (q_empty),
    .q_job            (pop_job),
    .q_pop            (q_pop),
    .drain_done       (drain_done),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_frame_code   (out_frame_code),
    .out_frame_length (out_frame_length),
    .out_has_payload  (out_has_payload),
    .out_payload_byte (out_payload_byte),
    .out_last         (out_last)
  );

endmodule

// File: verif/tb_top.sv
module tb_top;
  import xcfr_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int NUM_ROWS      = 26;
  // index 3 decodes to no register
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic [1:0] {RX_HEADER, RX_BODY, RX_CHECK} rx_phase_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] code;
    logic [6:0] length;
    logic       has_payload;
    logic [7:0] payload;
    logic       last;
  } frame_beat_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
    logic       typed;
    logic [2:0] st;
    logic [7:0] code;
    logic [7:0] len;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_command;
  logic [7:0]           in_rx_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [2:0]           out_status;
  logic [7:0]           out_frame_code;
  logic [6:0]           out_frame_length;
  logic                 out_has_payload;
  logic [7:0]           out_payload_byte;
  logic                 out_last;

  xor_checked_frame_receiver_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_frame_code   (out_frame_code),
    .out_frame_length (out_frame_length),
    .out_has_payload  (out_has_payload),
    .out_payload_byte (out_payload_byte),
    .out_last         (out_last)
  );

  // predictor copy of the registers and parser state
  logic [7:0]  start_cfg;
  logic [15:0] hdr_to_cfg;
  logic [15:0] body_to_cfg;
  rx_phase_t   ph;
  int          hdr_cnt;
  logic [7:0]  first_q;
  logic [7:0]  code_q;
  logic [7:0]  len_q;
  int          byte_cnt;
  logic [7:0]  xor_q;
  logic [15:0] tick_cnt;
  logic [7:0]  store_mem [0:MAX_PAYLOAD_DEF-1];

  frame_beat_t expected_beats [$];
  frame_beat_t typed_beat;
  logic        typed_on;
  logic        calm;
  logic        long_hold_done;
  int          beats_sent;
  int          fails;
  int          beats_checked;
  int          data_beats;
  int          status_beats;
  int          settings_run;
  stim_row_t   directed_rows [0:NUM_ROWS-1];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void open_window();
    ph       = RX_HEADER;
    hdr_cnt  = 0;
    first_q  = 8'h00;
    code_q   = 8'h00;
    len_q    = 8'h00;
    byte_cnt = 0;
    xor_q    = 8'h00;
    tick_cnt = 16'h0000;
  endfunction

  function automatic void push_status(logic [2:0] st, logic [7:0] code, logic [7:0] len);
    frame_beat_t r;
    r.status      = st;
    r.code        = code;
    r.length      = (len > 8'd127) ? 7'd127 : len[6:0];
    r.has_payload = 1'b0;
    r.payload     = 8'h00;
    r.last        = 1'b1;
    expected_beats.push_back(r);
    open_window();
  endfunction

  // one accepted beat through the parser; results go to expected_beats
  function automatic void parse_beat(logic cmd, logic [7:0] b);
    logic [15:0] limit;
    logic [16:0] t;
    frame_beat_t r;
    int          i;
    if (cmd == CMD_TICK) begin
      limit = (ph == RX_HEADER) ? hdr_to_cfg : body_to_cfg;
      t = {1'b0, tick_cnt} + 17'd1;
      if (t < {1'b0, limit}) begin
        tick_cnt = t[15:0];
      end else if (ph == RX_HEADER && hdr_cnt == 0) begin
        open_window();
      end else begin
        push_status(ST_TIMEOUT, code_q, len_q);
      end
      return;
    end
    case (ph)
      RX_HEADER: begin
        if (hdr_cnt == 0) begin
          first_q = b;
          hdr_cnt = 1;
        end else if (hdr_cnt == 1) begin
          code_q  = b;
          hdr_cnt = 2;
        end else if (first_q != start_cfg) begin
          push_status(ST_BAD_START, code_q, b);
        end else if (b > MAX_PAYLOAD_DEF) begin
          push_status(ST_TOO_LONG, code_q, b);
        end else begin
          len_q    = b;
          xor_q    = code_q ^ b;
          byte_cnt = 0;
          tick_cnt = 16'h0000;
          ph       = (b == 8'h00) ? RX_CHECK : RX_BODY;
        end
      end
      RX_BODY: begin
        if (byte_cnt < MAX_PAYLOAD_DEF) store_mem[byte_cnt] = b;
        xor_q = xor_q ^ b;
        byte_cnt++;
        if (byte_cnt >= len_q) begin
          ph       = RX_CHECK;
          tick_cnt = 16'h0000;
        end
      end
      default: begin
        if (b != xor_q) begin
          push_status(ST_BAD_SUM, code_q, len_q);
        end else if (len_q == 8'h00) begin
          push_status(ST_OK, code_q, 8'h00);
        end else begin
          for (i = 0; i < len_q; i++) begin
            r.status      = ST_OK;
            r.code        = code_q;
            r.length      = len_q[6:0];
            r.has_payload = 1'b1;
            r.payload     = store_mem[i];
            r.last        = (i == len_q - 1);
            expected_beats.push_back(r);
          end
          open_window();
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // scoreboard: outputs first, then register writes, then the input beat
  always @(posedge clk) begin
    frame_beat_t want;
    int          n0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat: status %0d code %0d", out_status, out_frame_code);
          fails++;
        end else begin
          want = expected_beats.pop_front();
          check_field("status", int'(want.status), int'(out_status));
          check_field("frame_code", int'(want.code), int'(out_frame_code));
          check_field("frame_length", int'(want.length), int'(out_frame_length));
          check_field("has_payload", int'(want.has_payload), int'(out_has_payload));
          check_field("payload_byte", int'(want.payload), int'(out_payload_byte));
          check_field("last", int'(want.last), int'(out_last));
        end
        beats_checked++;
        if (out_status == ST_OK) data_beats++;
        else status_beats++;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_START:   start_cfg   = cfg_wdata[7:0];
          CFG_HDR_TO:  hdr_to_cfg  = cfg_wdata[15:0];
          CFG_BODY_TO: body_to_cfg = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        n0 = expected_beats.size();
        parse_beat(in_command, in_rx_byte);
        if (typed_on) begin
          while (expected_beats.size() > n0) void'(expected_beats.pop_back());
          expected_beats.push_back(typed_beat);
        end
      end
    end
  end

  task automatic send_beat(logic cmd, logic [7:0] data);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_rx_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  // one frame, mostly well formed; garbage or cut ones only where a timeout can resync
  task automatic send_frame(int tick_odds, logic force_max);
    logic [8:0] seq [$];
    logic [7:0] code, len, check_byte, first, pick;
    logic       can_break;
    int         kind, i, cut;
    can_break = (hdr_to_cfg <= 16) && (body_to_cfg <= 16);
    kind = $urandom_range(0, 99);
    if (!can_break && (kind >= 94 || (kind >= 64 && kind < 72))) kind = 0;
    if (force_max) kind = 0;
    if (kind >= 94) begin
      repeat ($urandom_range(1, 6)) begin
        pick = 8'($urandom);
        seq.push_back({1'($urandom_range(0, 1)), pick});
      end
      repeat ($urandom_range(1, 17)) seq.push_back({CMD_TICK, 8'($urandom)});
    end else begin
      code = 8'($urandom);
      if (force_max) len = 8'(MAX_PAYLOAD_DEF);
      else if (kind >= 86) len = 8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255));
      else if ($urandom_range(0, 9) == 0) len = 8'($urandom_range(9, MAX_PAYLOAD_DEF - 1));
      else len = 8'($urandom_range(0, 8));
      first = start_cfg;
      if (kind >= 80 && kind < 86) first = start_cfg ^ 8'($urandom_range(1, 255));
      seq.push_back({CMD_BYTE, first});
      seq.push_back({CMD_BYTE, code});
      seq.push_back({CMD_BYTE, len});
      check_byte = code ^ len;
      if (first == start_cfg && len <= MAX_PAYLOAD_DEF) begin
        for (i = 0; i < len; i++) begin
          pick = 8'($urandom);
          check_byte ^= pick;
          seq.push_back({CMD_BYTE, pick});
        end
        if (kind >= 72 && kind < 80) check_byte ^= 8'($urandom_range(1, 255));
        seq.push_back({CMD_BYTE, check_byte});
      end
      if (kind >= 64 && kind < 72) begin
        cut = $urandom_range(1, seq.size() - 1);
        while (seq.size() > cut) void'(seq.pop_back());
        repeat ($urandom_range(1, 17)) seq.push_back({CMD_TICK, 8'($urandom)});
      end
    end
    foreach (seq[j]) begin
      if (tick_odds > 0 && $urandom_range(1, tick_odds) == 1)
        send_beat(CMD_TICK, 8'($urandom));
      send_beat(seq[j][8], seq[j][7:0]);
    end
  endtask

  task automatic run_phase(logic [7:0] start_v, logic [15:0] hdr_v, logic [15:0] body_v,
                           logic quiet, int tick_odds, int n_beats, logic with_max);
    logic [7:0] pad;
    int         stop_at;
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    pad = 8'($urandom);
    write_reg(CFG_START, {pad, start_v});
    write_reg(CFG_HDR_TO, hdr_v);
    write_reg(CFG_BODY_TO, body_v);
    write_reg(CFG_SPARE, 16'($urandom));
    cfg_we <= 1'b0;
    calm = quiet;
    settings_run++;
    stop_at = beats_sent + n_beats;
    if (with_max) send_frame(tick_odds, 1'b1);
    while (beats_sent < stop_at) send_frame(tick_odds, 1'b0);
  endtask

  // result side: random stall bursts, plus one long hold to back up the block
  initial begin : result_side
    int span;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!long_hold_done && beats_sent >= 110) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        span = $urandom_range(1, 12);
        repeat (span) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $error("run exceeded %0d cycles, %0d result beats still pending",
           LIMIT_CYCLES, expected_beats.size());
    $display("** xor_checked_frame_receiver_core: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int i;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_START;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_command     = CMD_BYTE;
    in_rx_byte     = 8'h00;
    typed_on       = 1'b0;
    typed_beat     = '0;
    calm           = 1'b0;
    long_hold_done = 1'b0;
    beats_sent     = 0;
    fails          = 0;
    beats_checked  = 0;
    data_beats     = 0;
    status_beats   = 0;
    settings_run   = 1;
    start_cfg      = START_RESET;
    hdr_to_cfg     = HDR_TO_RESET;
    body_to_cfg    = BODY_TO_RESET;
    open_window();

    // reset register values; typed rows carry their single status beat
    directed_rows = '{
      '{CMD_TICK, 8'h5A, 1'b0, ST_OK,        8'h00, 8'h00},
      // empty good frame
      '{CMD_BYTE, 8'hAA, 1'b0, ST_OK,        8'h00, 8'h00},
      '{CMD_BYTE, 8'h05, 1'b0, ST_OK,        8'h00, 8'h00},
      '{CMD_BYTE, 8'h00, 1'b0, ST_OK,        8'h00, 8'h00},
      '{CMD_BYTE, 8'h05, 1'b1, ST_OK,        8'h05, 8'h00},
      // wrong start byte
      '{CMD_BYTE, 8'h00, 1'b0, ST_OK,        8'h00, 8'h00},
      '{CMD_BYTE, 8'h12, 1'b0, ST_OK,        8'h00, 8'h00},
      '{CMD_BYTE, 8'h03, 1'b1, ST_BAD_START, 8'h12, 8'h03},
      // lengths past the buffer, 255 saturates to 127
      '{CMD_BYTE, 8'hAA, 1'b0, ST_OK,        8'h00, 8'h00},
      '{CMD_BYTE, 8'h34, 1'b0, ST_OK,        8'h00, 8'h00},
      '{CMD_BYTE, 8'hFF, 1'b1, ST_TOO_LONG,  8'h34, 8'd127},
      '{CMD_BYTE, 8'hAA, 1'b0, ST_OK,        8'h00, 8'h00},
      '{CMD_BYTE, 8'h77, 1'b0, ST_OK,        8'h00, 8'h00},
      '{CMD_BYTE, 8'h41, 1'b1, ST_TOO_LONG,  8'h77, 8'h41},
      // two-byte payload, tick while waiting for the checksum
      '{CMD_BYTE, 8'hAA, 1'b0, ST_OK,        8'h00, 8'h00},
      '{CMD_BYTE, 8'hFF, 1'b0, ST_OK,        8'h00, 8'h00},
      '{CMD_BYTE, 8'h02, 1'b0, ST_OK,        8'h00, 8'h00},
      '{CMD_BYTE, 8'h00, 1'b0, ST_OK,        8'h00, 8'h00},
      '{CMD_BYTE, 8'hFF, 1'b0, ST_OK,        8'h00, 8'h00},
      '{CMD_TICK, 8'hA5, 1'b0, ST_OK,        8'h00, 8'h00},
      '{CMD_BYTE, 8'h02, 1'b0, ST_OK,        8'h00, 8'h00},
      // checksum off by one bit pattern
      '{CMD_BYTE, 8'hAA, 1'b0, ST_OK,        8'h00, 8'h00},
      '{CMD_BYTE, 8'h01, 1'b0, ST_OK,        8'h00, 8'h00},
      '{CMD_BYTE, 8'h01, 1'b0, ST_OK,        8'h00, 8'h00},
      '{CMD_BYTE, 8'h80, 1'b0, ST_OK,        8'h00, 8'h00},
      '{CMD_BYTE, 8'h7F, 1'b1, ST_BAD_SUM,   8'h01, 8'h01}
    };

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < NUM_ROWS; i++) begin
      typed_on               = directed_rows[i].typed;
      typed_beat.status      = directed_rows[i].st;
      typed_beat.code        = directed_rows[i].code;
      typed_beat.length      = directed_rows[i].len[6:0];
      typed_beat.has_payload = 1'b0;
      typed_beat.payload     = 8'h00;
      typed_beat.last        = 1'b1;
      send_beat(directed_rows[i].cmd, directed_rows[i].data);
    end
    typed_on = 1'b0;

    // zero timeouts expire on the first tick; 65535 never does here
    run_phase(8'h00, 16'd0, 16'd0, 1'b0, 12, 50, 1'b0);
    run_phase(8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 6, 80, 1'b1);
    run_phase(8'($urandom), 16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
              1'b0, 10, 60, 1'b0);
    run_phase(8'hAA, 16'd3, 16'd1, 1'b0, 15, 50, 1'b0);
    // back to reset values, no idling on either side
    run_phase(START_RESET, HDR_TO_RESET, BODY_TO_RESET, 1'b1, 8, 70, 1'b1);

    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d input beats under %0d register settings.",
             beats_sent, settings_run);
    $display("Compared %0d result beats: %0d good-frame beats, %0d status beats.",
             beats_checked, data_beats, status_beats);
    if (fails == 0)
      $display("** xor_checked_frame_receiver_core: PASSED **");
    else
      $display("** xor_checked_frame_receiver_core: FAILED **");
    $finish;
  end

endmodule
